@@ sv/gsp_pkg.sv @@
`timescale 1ns / 1ps

package gsp_pkg;

	localparam int unsigned CAPACITY_DEFAULT = 256;

	localparam int SLOT_IDX_W = 8;
	localparam int GEN_W      = 32;
	localparam int EPOCH_W    = 32;
	localparam int COUNT_W    = 9;

	localparam logic [GEN_W-1:0] MAX_GEN = '1;

	typedef enum logic [1:0] {
		KIND_ALLOC,
		KIND_RELEASE,
		KIND_CHECK,
		KIND_EPOCH
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_EMPTY,
		ST_EPOCH,
		ST_STALE,
		ST_IGNORED
	} status_t;

	// act counts only while tag equals the current epoch
	typedef struct packed {
		logic               act;
		logic [EPOCH_W-1:0] tag;
		logic [GEN_W-1:0]   gen;
	} slot_entry_t;

	typedef struct packed {
		logic rd;
		logic we;
	} tbl_ctl_t;

	typedef struct packed {
		logic pop;
		logic push;
		logic clear;
	} stk_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} stk_stat_t;

endpackage

@@ sv/gsp_req_if.sv @@
`timescale 1ns / 1ps

interface gsp_req_if;
	import gsp_pkg::*;

	logic                  valid;
	logic                  ready;
	kind_t                 kind;
	logic [SLOT_IDX_W-1:0] slot_index;
	logic [GEN_W-1:0]      handle_generation;
	logic [EPOCH_W-1:0]    epoch_value;

	modport source (
		output valid, kind, slot_index, handle_generation, epoch_value,
		input  ready
	);

	modport sink (
		input  valid, kind, slot_index, handle_generation, epoch_value,
		output ready
	);

endinterface

@@ sv/gsp_rsp_if.sv @@
`timescale 1ns / 1ps

interface gsp_rsp_if;
	import gsp_pkg::*;

	logic                  valid;
	logic                  ready;
	status_t               status;
	logic [SLOT_IDX_W-1:0] granted_slot;
	logic [GEN_W-1:0]      granted_generation;
	logic [EPOCH_W-1:0]    current_epoch;
	logic [COUNT_W-1:0]    active_count;
	logic [COUNT_W-1:0]    peak_active;

	modport source (
		output valid, status, granted_slot, granted_generation, current_epoch,
			active_count, peak_active,
		input  ready
	);

	modport sink (
		input  valid, status, granted_slot, granted_generation, current_epoch,
			active_count, peak_active,
		output ready
	);

endinterface

@@ sv/generational_slot_pool.sv @@
`timescale 1ns / 1ps

// channel  dir  modport  payload
// req      in   sink     kind, slot_index, handle_generation, epoch_value
// rsp      out  source   status, granted_slot, granted_generation, current_epoch,
//                        active_count, peak_active
//
// one request at a time: a rejected request or begin epoch goes from accept through
// ISSUE to DONE, release and check also through SLOT, allocate through STACK and SLOT
// (free stack read, then slot table read-modify-write, each through its memory port).
// req.ready returns when the result is loaded into the output register.
// after reset the slot table clears every entry; req.ready stays low until it is done.
// a result waits in the output register; the next request is taken meanwhile,
// and its result stalls until the held one is taken.

module generational_slot_pool #(
	parameter int unsigned CAPACITY = gsp_pkg::CAPACITY_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	gsp_req_if.sink   req,
	gsp_rsp_if.source rsp
);
	import gsp_pkg::*;

	localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ISSUE,
		S_STACK,
		S_SLOT,
		S_DONE
	} state_t;

	state_t                state_q;
	kind_t                 kind_q;
	logic [SLOT_IDX_W-1:0] slot_q;
	logic [GEN_W-1:0]      gen_q;
	logic [EPOCH_W-1:0]    epv_q;
	logic [EPOCH_W-1:0]    epoch_q;
	logic [CNT_W-1:0]      active_q;
	logic [CNT_W-1:0]      peak_q;
	logic [SLOT_W-1:0]     idx_q;
	status_t               status_q;
	logic [SLOT_IDX_W-1:0] gslot_q;
	logic [GEN_W-1:0]      ggen_q;

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [SLOT_IDX_W-1:0] out_gslot_q;
	logic [GEN_W-1:0]      out_ggen_q;
	logic [EPOCH_W-1:0]    out_epoch_q;
	logic [CNT_W-1:0]      out_active_q;
	logic [CNT_W-1:0]      out_peak_q;

	tbl_ctl_t          tbl_ctl;
	logic [SLOT_W-1:0] tbl_rd_addr;
	slot_entry_t       tbl_wr_data;
	slot_entry_t       ent;
	logic              tbl_busy;
	stk_ctl_t          stk_ctl;
	logic [SLOT_W-1:0] stk_top;
	stk_stat_t         stk_stat;

	logic              epoch_ok;
	logic              handle_ok;
	logic              new_epoch_ok;
	logic              match;
	logic [GEN_W-1:0]  next_gen;
	logic [CNT_W-1:0]  active_inc;
	logic              out_load;

	assign epoch_ok     = (epoch_q != '0) && (epv_q == epoch_q);
	assign handle_ok    = (gen_q != '0) && (32'(slot_q) < 32'(CAPACITY));
	assign new_epoch_ok = (epv_q != '0) && (epv_q > epoch_q);
	assign match        = ent.act && (ent.tag == epoch_q) && (ent.gen == gen_q);
	assign next_gen     = (ent.gen == MAX_GEN) ? GEN_W'(1) : ent.gen + GEN_W'(1);
	assign active_inc   = active_q + CNT_W'(1);
	assign out_load     = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		tbl_ctl     = '0;
		tbl_rd_addr = SLOT_W'(slot_q);
		tbl_wr_data = '{act: 1'b1, tag: epoch_q, gen: next_gen};
		stk_ctl     = '0;
		unique case (state_q)
			S_ISSUE: begin
				unique case (kind_q)
					KIND_ALLOC: stk_ctl.pop = epoch_ok && !stk_stat.empty;
					KIND_RELEASE, KIND_CHECK: tbl_ctl.rd = epoch_ok && handle_ok;
					KIND_EPOCH: stk_ctl.clear = new_epoch_ok;
				endcase
			end
			S_STACK: begin
				tbl_ctl.rd  = 1'b1;
				tbl_rd_addr = stk_top;
			end
			S_SLOT: begin
				if (kind_q == KIND_ALLOC) begin
					tbl_ctl.we = 1'b1;
				end else if (kind_q == KIND_RELEASE && match) begin
					tbl_ctl.we   = 1'b1;
					tbl_wr_data  = '{act: 1'b0, tag: ent.tag, gen: ent.gen};
					stk_ctl.push = !stk_stat.full;
				end
			end
			default: ;
		endcase
	end

	gsp_slot_table #(
		.CAPACITY (CAPACITY),
		.SLOT_W   (SLOT_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tbl_ctl),
		.rd_addr (tbl_rd_addr),
		.wr_addr (idx_q),
		.wr_data (tbl_wr_data),
		.rd_data (ent),
		.busy    (tbl_busy)
	);

	gsp_free_stack #(
		.CAPACITY (CAPACITY),
		.SLOT_W   (SLOT_W),
		.CNT_W    (CNT_W)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (stk_ctl),
		.push_slot (idx_q),
		.top_slot  (stk_top),
		.stat      (stk_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			epoch_q     <= '0;
			active_q    <= '0;
			peak_q      <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						kind_q  <= req.kind;
						slot_q  <= req.slot_index;
						gen_q   <= req.handle_generation;
						epv_q   <= req.epoch_value;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					gslot_q <= '0;
					ggen_q  <= '0;
					unique case (kind_q)
						KIND_ALLOC: begin
							if (!epoch_ok) begin
								status_q <= ST_EPOCH;
								state_q  <= S_DONE;
							end else if (stk_stat.empty) begin
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_STACK;
							end
						end
						KIND_RELEASE, KIND_CHECK: begin
							idx_q <= SLOT_W'(slot_q);
							if (!epoch_ok) begin
								status_q <= ST_EPOCH;
								state_q  <= S_DONE;
							end else if (!handle_ok) begin
								status_q <= ST_STALE;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_SLOT;
							end
						end
						KIND_EPOCH: begin
							if (new_epoch_ok) begin
								epoch_q  <= epv_q;
								active_q <= '0;
								peak_q   <= '0;
								status_q <= ST_OK;
							end else begin
								status_q <= ST_IGNORED;
							end
							state_q <= S_DONE;
						end
					endcase
				end
				S_STACK: begin
					idx_q   <= stk_top;
					state_q <= S_SLOT;
				end
				S_SLOT: begin
					unique case (kind_q)
						KIND_ALLOC: begin
							status_q <= ST_OK;
							gslot_q  <= SLOT_IDX_W'(idx_q);
							ggen_q   <= next_gen;
							active_q <= active_inc;
							if (active_inc > peak_q) begin
								peak_q <= active_inc;
							end
						end
						KIND_RELEASE: begin
							if (match) begin
								status_q <= ST_OK;
								if (active_q != '0) begin
									active_q <= active_q - CNT_W'(1);
								end
							end else begin
								status_q <= ST_STALE;
							end
						end
						default: status_q <= match ? ST_OK : ST_STALE;
					endcase
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_status_q <= status_q;
						out_gslot_q  <= gslot_q;
						out_ggen_q   <= ggen_q;
						out_epoch_q  <= epoch_q;
						out_active_q <= active_q;
						out_peak_q   <= peak_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready              = (state_q == S_IDLE) && !tbl_busy;
	assign rsp.valid              = out_valid_q;
	assign rsp.status             = out_status_q;
	assign rsp.granted_slot       = out_gslot_q;
	assign rsp.granted_generation = out_ggen_q;
	assign rsp.current_epoch      = out_epoch_q;
	assign rsp.active_count       = COUNT_W'(out_active_q);
	assign rsp.peak_active        = COUNT_W'(out_peak_q);

endmodule

@@ sv/gsp_slot_table.sv @@
`timescale 1ns / 1ps

module gsp_slot_table #(
	parameter int unsigned CAPACITY = gsp_pkg::CAPACITY_DEFAULT,
	parameter int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gsp_pkg::tbl_ctl_t    ctl,
	input  logic [SLOT_W-1:0]    rd_addr,
	input  logic [SLOT_W-1:0]    wr_addr,
	input  gsp_pkg::slot_entry_t wr_data,
	output gsp_pkg::slot_entry_t rd_data,
	output logic                 busy
);
	import gsp_pkg::*;

	slot_entry_t       mem [CAPACITY];
	slot_entry_t       rd_q;
	logic              busy_q;
	logic [SLOT_W-1:0] clr_q;

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == SLOT_W'(CAPACITY - 1)) begin
				busy_q <= 1'b0;
			end
			clr_q <= clr_q + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (ctl.we) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
	assign busy    = busy_q;

endmodule

@@ sv/gsp_free_stack.sv @@
`timescale 1ns / 1ps

module gsp_free_stack #(
	parameter int unsigned CAPACITY = gsp_pkg::CAPACITY_DEFAULT,
	parameter int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	parameter int CNT_W  = $clog2(CAPACITY + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gsp_pkg::stk_ctl_t  ctl,
	input  logic [SLOT_W-1:0]  push_slot,
	output logic [SLOT_W-1:0]  top_slot,
	output gsp_pkg::stk_stat_t stat
);
	import gsp_pkg::*;

	logic [SLOT_W-1:0] mem [CAPACITY];
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  low_q;
	logic [CNT_W-1:0]  fill_dec;
	logic [SLOT_W-1:0] rd_s1;
	logic [SLOT_W-1:0] pos_s1;
	logic              fresh_s1;

	assign fill_dec = fill_q - CNT_W'(1);

	// positions below the low mark still hold the initial order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= CNT_W'(CAPACITY);
			low_q  <= CNT_W'(CAPACITY);
		end else if (ctl.clear) begin
			fill_q <= CNT_W'(CAPACITY);
			low_q  <= CNT_W'(CAPACITY);
		end else if (ctl.pop) begin
			fill_q <= fill_dec;
			if (fill_dec < low_q) begin
				low_q <= fill_dec;
			end
		end else if (ctl.push) begin
			fill_q <= fill_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[fill_q[SLOT_W-1:0]] <= push_slot;
		end
		if (ctl.pop) begin
			rd_s1    <= mem[fill_dec[SLOT_W-1:0]];
			pos_s1   <= fill_dec[SLOT_W-1:0];
			fresh_s1 <= (fill_q == low_q);
		end
	end

	assign top_slot   = fresh_s1 ? (SLOT_W'(CAPACITY - 1) - pos_s1) : rd_s1;
	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == CNT_W'(CAPACITY));

endmodule
